@@ rtl/core/sit_pkg.sv @@
// Package for the string intern table: sizes, codes and the controller state type.
// Used by string_intern_table, sit_mod and the testbench; depends on nothing.
`timescale 1ns / 1ps
package sit_pkg;

   localparam int SLOTS       = 256;
   localparam int STORE_BYTES = 4096;
   localparam int MAX_LEN     = 64;

   localparam int SLOT_W  = $clog2(SLOTS);          // slot index
   localparam int CNT_W   = $clog2(SLOTS) + 1;      // slot count, probe count
   localparam int SADDR_W = $clog2(STORE_BYTES);    // store offset
   localparam int USED_W  = $clog2(STORE_BYTES) + 1;
   localparam int PADDR_W = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN) + 1;

   localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TABLE_FULL = 3'd1,
      ST_STORE_FULL = 3'd2,
      ST_BAD_INTERN = 3'd3,
      ST_TOO_LONG   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_PROBE, S_SLOT, S_CMP_RD, S_CMP_CHK,
      S_CP_RD, S_CP_WR, S_NUL, S_LOOK, S_EMIT
   } state_type;

endpackage

@@ rtl/core/string_intern_table.sv @@
// Top level of the string intern table: controller, slot table, byte store and pending buffer.
// Depends on sit_pkg, sit_ram and sit_mod.
`timescale 1ns / 1ps
// How the block is used.
// Items arrive on the req_ stream. With req_tuser low, req_tdata carries one string byte;
// a non-zero byte is hashed and buffered and gives no result, while a zero byte ends the
// string and gives one result on the rsp_ stream. With req_tuser high the item is a
// lookup of the start offset recorded for an intern index, and always gives one result.
// The csr_ channel writes the slot count; it should only be written while the block is
// idle, and it is always ready.
// A string byte is handled as it is accepted. A string end first reduces the hash modulo
// the slot count in the bit-serial remainder unit, then probes slot after slot (skipping
// slot zero) and compares the stored string one byte read at a time, since the byte store
// has a single read port. An insertion copies the string byte by byte and then writes the
// terminating zero. A lookup reads the slot table, and skips that read when the index is
// zero or beyond the slot count.
// One item is worked on at a time; req_tready is high only while the controller is idle.
// The result waits in an output register, so the next item is accepted while an earlier
// result is still held because the receiver stalls.
// Reset empties the table at once by clearing the slot valid flags, sets the store fill
// count to one (the empty string at offset zero) and the slot count to 256. No clearing
// pass is needed.
module string_intern_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // byte_value [7:0], query_intern [15:8]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // status [2:0], intern [10:3], start_offset [22:11],
                                   // was_new [23]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data    // slot_count
);
   import sit_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   slot_count_ff, n_eff;
   logic [31:0]        hash_ff, hash_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               over_ff, over_in;
   logic               str_ff, str_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]   slot_vld_ff;
   logic               vld_q_ff;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   tries_ff, tries_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic [SADDR_W-1:0] s_ff, s_in;

   logic [2:0]         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_intern_ff, res_intern_in;
   logic [SADDR_W-1:0] res_off_ff, res_off_in;
   logic               res_new_ff, res_new_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]        rsp_tdata_ff, rsp_tdata_in;

   logic               acc, out_free, mod_start, mod_done, probe_hit;
   logic [SLOT_W-1:0]  mod_rem, idx_next;
   logic [7:0]         byte_v;
   logic [SLOT_W-1:0]  query;
   logic [USED_W:0]    need_end;

   logic               slot_we;
   logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
   logic [SADDR_W-1:0] slot_wdata, slot_rdata;
   logic               store_we;
   logic [SADDR_W-1:0] store_waddr, store_raddr;
   logic [7:0]         store_wdata, store_rdata;
   logic               pend_we;
   logic [PADDR_W-1:0] pend_waddr, pend_raddr;
   logic [7:0]         pend_rdata, want;

   assign acc      = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign byte_v   = req_tdata[7:0];
   assign query    = req_tdata[15:8];
   assign csr_ready = 1'b1;

   // Out-of-range slot counts are clamped to the legal span.
   always_comb begin
      if (slot_count_ff < CNT_W'(2)) begin
         n_eff = CNT_W'(2);
      end else if (slot_count_ff > CNT_W'(SLOTS)) begin
         n_eff = CNT_W'(SLOTS);
      end else begin
         n_eff = slot_count_ff;
      end
   end

   assign idx_next = ({1'b0, idx_ff} + CNT_W'(1) == n_eff) ? '0 : idx_ff + SLOT_W'(1);
   assign need_end = (USED_W+1)'(used_ff) + (USED_W+1)'(len_ff) + (USED_W+1)'(1);
   assign want     = (k_ff < len_ff) ? pend_rdata : 8'd0;
   assign probe_hit = (store_rdata == want);

   sit_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_ff),
      .divisor   (n_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   sit_ram #(.WIDTH(SADDR_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock), .wr_en (slot_we), .wr_addr (slot_waddr), .wr_data (slot_wdata),
      .rd_addr (slot_raddr), .rd_data (slot_rdata)
   );

   sit_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store_ram (
      .clock (clock), .wr_en (store_we), .wr_addr (store_waddr), .wr_data (store_wdata),
      .rd_addr (store_raddr), .rd_data (store_rdata)
   );

   sit_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pend_ram (
      .clock (clock), .wr_en (pend_we), .wr_addr (pend_waddr), .wr_data (byte_v),
      .rd_addr (pend_raddr), .rd_data (pend_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_tuser) begin
                  if (query == '0 || {1'b0, query} >= n_eff) begin
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_LOOK;
                  end
               end else if (byte_v == 8'd0) begin
                  state_in = (over_ff || len_ff == '0) ? S_EMIT : S_MOD;
               end
            end
         end
         S_MOD:     if (mod_done) state_in = S_PROBE;
         S_PROBE: begin
            if (tries_ff == n_eff) begin
               state_in = S_EMIT;
            end else if (idx_ff != '0) begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (vld_q_ff) begin
               state_in = S_CMP_RD;
            end else if (need_end > (USED_W+1)'(STORE_BYTES)) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_CMP_RD:  state_in = S_CMP_CHK;
         S_CMP_CHK: begin
            if (!probe_hit) begin
               state_in = S_PROBE;
            end else if (k_ff == len_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_CMP_RD;
            end
         end
         S_CP_RD:   state_in = S_CP_WR;
         S_CP_WR:   state_in = (k_ff + LEN_W'(1) == len_ff) ? S_NUL : S_CP_RD;
         S_NUL:     state_in = S_EMIT;
         S_LOOK:    state_in = S_EMIT;
         S_EMIT:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath, memory controls and results.
   always_comb begin
      req_tready    = (state_ff == S_IDLE);
      hash_in       = hash_ff;
      len_in        = len_ff;
      over_in       = over_ff;
      str_in        = str_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      tries_in      = tries_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      res_status_in = res_status_ff;
      res_intern_in = res_intern_ff;
      res_off_in    = res_off_ff;
      res_new_in    = res_new_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mod_start     = 1'b0;
      slot_we       = 1'b0;
      slot_waddr    = idx_ff;
      slot_wdata    = used_ff[SADDR_W-1:0];
      slot_raddr    = idx_ff;
      store_we      = 1'b0;
      store_waddr   = SADDR_W'(used_ff + USED_W'(k_ff));
      store_wdata   = pend_rdata;
      store_raddr   = SADDR_W'(s_ff + SADDR_W'(k_ff));
      pend_we       = 1'b0;
      pend_waddr    = len_ff[PADDR_W-1:0];
      pend_raddr    = k_ff[PADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            slot_raddr = query;
            res_status_in = ST_OK;
            res_intern_in = '0;
            res_off_in    = '0;
            res_new_in    = 1'b0;
            if (acc) begin
               if (req_tuser) begin
                  str_in = 1'b0;
                  // An index at or beyond the slot count is refused with a zero intern.
                  if (query != '0 && {1'b0, query} >= n_eff) begin
                     res_status_in = ST_BAD_INTERN;
                  end else begin
                     res_intern_in = query;
                  end
               end else if (byte_v != 8'd0) begin
                  if (len_ff < LEN_W'(MAX_LEN)) begin
                     pend_we = 1'b1;
                     len_in  = len_ff + LEN_W'(1);
                     hash_in = (hash_ff ^ {24'd0, byte_v}) * FNV_PRIME;
                  end else begin
                     over_in = 1'b1;
                  end
               end else begin
                  str_in = 1'b1;
                  if (over_ff) begin
                     res_status_in = ST_TOO_LONG;
                  end else if (len_ff != '0) begin
                     mod_start = 1'b1;
                  end
               end
            end
         end
         S_MOD: begin
            idx_in   = mod_rem;
            tries_in = '0;
         end
         S_PROBE: begin
            k_in = '0;
            if (tries_ff == n_eff) begin
               res_status_in = ST_TABLE_FULL;
            end else if (idx_ff == '0) begin
               idx_in   = idx_next;
               tries_in = tries_ff + CNT_W'(1);
            end
         end
         S_SLOT: begin
            s_in = slot_rdata;
            if (!vld_q_ff && need_end > (USED_W+1)'(STORE_BYTES)) begin
               res_status_in = ST_STORE_FULL;
            end
         end
         S_CMP_RD: begin
         end
         S_CMP_CHK: begin
            if (!probe_hit) begin
               idx_in   = idx_next;
               tries_in = tries_ff + CNT_W'(1);
            end else if (k_ff == len_ff) begin
               res_intern_in = idx_ff;
               res_off_in    = s_ff;
            end else begin
               k_in = k_ff + LEN_W'(1);
            end
         end
         S_CP_RD: begin
         end
         S_CP_WR: begin
            store_we = 1'b1;
            k_in     = k_ff + LEN_W'(1);
         end
         S_NUL: begin
            store_we      = 1'b1;
            store_waddr   = SADDR_W'(used_ff + USED_W'(len_ff));
            store_wdata   = 8'd0;
            slot_we       = 1'b1;
            res_intern_in = idx_ff;
            res_off_in    = used_ff[SADDR_W-1:0];
            res_new_in    = 1'b1;
            used_in       = USED_W'(need_end);
         end
         S_LOOK: begin
            if (vld_q_ff) begin
               res_off_in = slot_rdata;
            end else begin
               res_status_in = ST_BAD_INTERN;
               res_intern_in = '0;
            end
         end
         S_EMIT: begin
            if (str_ff) begin
               len_in  = '0;
               hash_in = FNV_BASIS;
               over_in = 1'b0;
            end
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_new_ff, res_off_ff, res_intern_ff, res_status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= CNT_W'(SLOTS);
         hash_ff       <= FNV_BASIS;
         len_ff        <= '0;
         over_ff       <= 1'b0;
         str_ff        <= 1'b0;
         used_ff       <= USED_W'(1);
         slot_vld_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         len_ff        <= len_in;
         over_ff       <= over_in;
         str_ff        <= str_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_data;
         end
         if (slot_we) begin
            slot_vld_ff[slot_waddr] <= 1'b1;
         end
      end
      vld_q_ff      <= slot_vld_ff[slot_raddr];
      idx_ff        <= idx_in;
      tries_ff      <= tries_in;
      k_ff          <= k_in;
      s_ff          <= s_in;
      res_status_ff <= res_status_in;
      res_intern_ff <= res_intern_in;
      res_off_ff    <= res_off_in;
      res_new_ff    <= res_new_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The fill count never passes the end of the store.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(STORE_BYTES))
      else $error("store fill count beyond store size");

   // The slot kept for the empty string is never taken.
   a_slot0_free: assert property (@(posedge clock) disable iff (reset)
      !slot_vld_ff[0])
      else $error("reserved slot written");

   // A slot is only filled when it was empty.
   a_fill_empty: assert property (@(posedge clock) disable iff (reset)
      slot_we |-> !slot_vld_ff[slot_waddr])
      else $error("occupied slot overwritten");

   // The byte compare never runs past the terminating zero.
   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP_CHK |-> k_ff <= len_ff)
      else $error("compare index past string end");
endmodule

@@ rtl/core/sit_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module sit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/sit_mod.sv @@
// Bit-serial remainder unit: 32-bit hash modulo the slot count, one bit per cycle.
// Depends on sit_pkg.
`timescale 1ns / 1ps
module sit_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [sit_pkg::CNT_W-1:0]  divisor,
   output logic                       done,
   output logic [sit_pkg::SLOT_W-1:0] remainder
);
   import sit_pkg::*;

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];
endmodule

@@ tb/string_intern_table_tb.sv @@
// Self-checking testbench for the string intern table: directed table, random strings and lookups.
// Depends on sit_pkg and the string_intern_table RTL; needs no other file.
`timescale 1ns / 1ps
module string_intern_table_tb;
   import sit_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int SETTLE       = 40;

   // One expected or observed result beat.
   typedef struct packed {
      status_type  status;
      logic [7:0]  intern;
      logic [11:0] start_offset;
      logic        was_new;
   } intern_result_type;

   // Tag that travels with every request beat: typed results override the prediction.
   typedef struct {
      bit                typed;
      intern_result_type res;
   } req_tag_type;

   // One row of the directed table.
   typedef struct {
      bit             lookup;
      logic [7:0]     value;
      bit             typed;
      status_type     status;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_data = 9'd256;

   string_intern_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the block's state, kept by the predictor.
   logic [11:0] shadow_slot_start [SLOTS];
   logic [7:0]  shadow_store [STORE_BYTES];
   int unsigned shadow_used;
   logic [7:0]  shadow_pending [MAX_LEN];
   int unsigned shadow_len;
   logic [31:0] shadow_hash;
   bit          shadow_overlong;
   logic [8:0]  shadow_slot_count;

   intern_result_type expected_results[$];
   req_tag_type       beat_tags[$];

   int  mismatches    = 0;
   int  results_seen  = 0;
   int  items_sent    = 0;
   int  inserts_seen  = 0;
   int  errors_seen   = 0;
   int  cycle_count   = 0;
   bit  calm          = 1'b0;   // no idling on either side while set
   int  hold_requests = 0;

   function automatic int unsigned usable_slots();
      if (shadow_slot_count < 2) return 2;
      if (shadow_slot_count > SLOTS) return SLOTS;
      return shadow_slot_count;
   endfunction

   function automatic intern_result_type make_result(status_type st, int unsigned idx,
                                                     int unsigned offs, bit fresh);
      intern_result_type r;
      r.status       = st;
      r.intern       = idx[7:0];
      r.start_offset = offs[11:0];
      r.was_new      = fresh;
      return r;
   endfunction

   function automatic void reset_shadow();
      foreach (shadow_slot_start[i]) shadow_slot_start[i] = '0;
      foreach (shadow_store[i]) shadow_store[i] = '0;
      foreach (shadow_pending[i]) shadow_pending[i] = '0;
      shadow_used       = 1;
      shadow_len        = 0;
      shadow_hash       = FNV_BASIS;
      shadow_overlong   = 1'b0;
      shadow_slot_count = 9'd256;
   endfunction

   // Does the stored string at offs equal the pending string, terminator included?
   function automatic bit stored_equals(int unsigned offs);
      logic [7:0] want;
      for (int unsigned k = 0; k <= shadow_len; k++) begin
         want = (k < shadow_len) ? shadow_pending[k] : 8'd0;
         if (offs + k >= STORE_BYTES) return 1'b0;
         if (shadow_store[offs + k] != want) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Probe from the hashed slot, skipping the reserved slot 0, and intern the string.
   function automatic intern_result_type probe_and_intern();
      int unsigned n;
      int unsigned idx;
      int unsigned s;
      n   = usable_slots();
      idx = shadow_hash % n;
      for (int unsigned tries = 0; tries < n; tries++) begin
         if (idx != 0) begin
            s = shadow_slot_start[idx];
            if (s != 0) begin
               if (stored_equals(s)) return make_result(ST_OK, idx, s, 1'b0);
            end else begin
               if (STORE_BYTES - shadow_used < shadow_len + 1)
                  return make_result(ST_STORE_FULL, 0, 0, 1'b0);
               s = shadow_used;
               for (int unsigned k = 0; k < shadow_len; k++)
                  shadow_store[s + k] = shadow_pending[k];
               shadow_store[s + shadow_len] = 8'd0;
               shadow_used += shadow_len + 1;
               shadow_slot_start[idx] = s[11:0];
               return make_result(ST_OK, idx, s, 1'b1);
            end
         end
         idx = (idx + 1) % n;
      end
      return make_result(ST_TABLE_FULL, 0, 0, 1'b0);
   endfunction

   // Advances the shadow state by one accepted beat; returns 1 when a result is due.
   function automatic bit predict_intern(input bit lookup, input logic [7:0] value,
                                         input logic [7:0] query,
                                         output intern_result_type res);
      int unsigned s;
      if (lookup) begin
         if (query == 0) res = make_result(ST_OK, 0, 0, 1'b0);
         else if (query >= usable_slots() || shadow_slot_start[query] == 0)
            res = make_result(ST_BAD_INTERN, 0, 0, 1'b0);
         else begin
            s   = shadow_slot_start[query];
            res = make_result(ST_OK, query, s, 1'b0);
         end
         return 1'b1;
      end
      if (value != 0) begin
         if (shadow_len < MAX_LEN) begin
            shadow_pending[shadow_len] = value;
            shadow_len++;
            shadow_hash = (shadow_hash ^ {24'd0, value}) * FNV_PRIME;
         end else
            shadow_overlong = 1'b1;
         return 1'b0;
      end
      if (shadow_overlong) res = make_result(ST_TOO_LONG, 0, 0, 1'b0);
      else if (shadow_len == 0) res = make_result(ST_OK, 0, 0, 1'b0);
      else res = probe_and_intern();
      shadow_len      = 0;
      shadow_hash     = FNV_BASIS;
      shadow_overlong = 1'b0;
      return 1'b1;
   endfunction

   // Request side monitor: predicts on every accepted beat, follows register writes.
   always @(posedge clock) begin
      intern_result_type res;
      req_tag_type       tag;
      if (!reset) begin
         if (csr_valid && csr_ready) shadow_slot_count <= csr_data;
         if (req_tvalid && req_tready) begin
            tag = beat_tags.pop_front();
            if (predict_intern(req_tuser, req_tdata[7:0], req_tdata[15:8], res)) begin
               if (tag.typed) res = tag.res;
               expected_results.push_back(res);
            end
         end
      end
   end

   // Result side: compares each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      intern_result_type got;
      intern_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = status_type'(rsp_tdata[2:0]);
         got.intern       = rsp_tdata[10:3];
         got.start_offset = rsp_tdata[22:11];
         got.was_new      = rsp_tdata[23];
         results_seen++;
         if (got.was_new) inserts_seen++;
         if (got.status != ST_OK) errors_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: status %0d intern %0d offset %0d new %0b",
                        got.status, got.intern, got.start_offset, got.was_new);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch at result %0d: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                           results_seen, want.status, want.intern, want.start_offset,
                           want.was_new, got.status, got.intern, got.start_offset,
                           got.was_new);
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      int served;
      int hold_left;
      if (reset) begin
         served    = 0;
         hold_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (served != hold_requests) begin
            served    = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offers one beat, sometimes after a random gap. The valid is left high on return so that
   // back-to-back beats never see a second assignment in the same step.
   task automatic send_beat(input bit lookup, input logic [7:0] value,
                            input logic [7:0] query, input bit typed = 1'b0,
                            input status_type st = ST_OK);
      req_tag_type tag;
      tag.typed = typed;
      tag.res   = make_result(st, 0, 0, 1'b0);
      if (!calm && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      beat_tags.push_back(tag);
      req_tvalid <= 1'b1;
      req_tuser  <= lookup;
      req_tdata  <= {query, value};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Lowers the valid and waits until every expected result is in, then lets the
   // controller finish any byte still in flight.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [8:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends a string of len bytes; a vocabulary word repeats so that matches occur,
   // otherwise the bytes are random non-zero values. Lookups may fall mid-string.
   task automatic send_string(input int len, input int word, input bit mix_lookups);
      logic [7:0] b;
      for (int k = 0; k < len; k++) begin
         if (word >= 0) b = 8'((word * 37 + k * 91) | 1);
         else b = 8'($urandom_range(255, 1));
         if (mix_lookups && $urandom_range(99) < 10)
            send_beat(1'b1, 8'($urandom), 8'($urandom));
         send_beat(1'b0, b, 8'($urandom));
      end
      send_beat(1'b0, 8'd0, 8'($urandom));
   endtask

   task automatic random_phase(input int beats);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < beats) begin
         pick = $urandom_range(99);
         if (pick < 25) send_beat(1'b1, 8'($urandom), 8'($urandom));
         else if (pick < 60) send_string($urandom_range(6, 1), $urandom_range(15), 1'b1);
         else if (pick < 88) send_string($urandom_range(8, 1), -1, 1'b1);
         else if (pick < 93) send_string(0, -1, 1'b0);
         else send_string($urandom_range(70, 62), -1, 1'b0);
      end
   endtask

   // Directed table: extremes of each field, both commands, reserved slot, repeats.
   dir_row_type directed [] = '{
      '{1'b1, 8'd0,   1'b1, ST_OK},          // lookup of the empty string's index
      '{1'b1, 8'd255, 1'b1, ST_BAD_INTERN},  // highest index, slot still empty
      '{1'b1, 8'd1,   1'b1, ST_BAD_INTERN},
      '{1'b0, 8'd0,   1'b1, ST_OK},          // empty string
      '{1'b0, 8'h41,  1'b0, ST_OK},
      '{1'b0, 8'd0,   1'b0, ST_OK},          // first insertion
      '{1'b0, 8'h41,  1'b0, ST_OK},
      '{1'b0, 8'd0,   1'b0, ST_OK},          // same string again, found
      '{1'b0, 8'hff,  1'b0, ST_OK},
      '{1'b0, 8'h80,  1'b0, ST_OK},
      '{1'b1, 8'd0,   1'b1, ST_OK},          // lookup in the middle of a string
      '{1'b0, 8'h01,  1'b0, ST_OK},
      '{1'b0, 8'h7f,  1'b0, ST_OK},
      '{1'b0, 8'd0,   1'b0, ST_OK},
      '{1'b0, 8'haa,  1'b0, ST_OK},
      '{1'b0, 8'h55,  1'b0, ST_OK},
      '{1'b0, 8'd0,   1'b0, ST_OK},
      '{1'b1, 8'd255, 1'b0, ST_OK},
      '{1'b1, 8'd128, 1'b0, ST_OK}
   };

   initial begin
      logic [8:0] settings [8] = '{9'd1, 9'd0, 9'd3, 9'd300, 9'd511, 9'd37, 9'd2, 9'd256};
      reset_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_beat(directed[i].lookup, directed[i].lookup ? 8'h00 : directed[i].value,
                   directed[i].lookup ? directed[i].value : 8'h00,
                   directed[i].typed, directed[i].status);
      // One byte past the length limit, then a string of exactly the limit.
      for (int k = 0; k <= MAX_LEN; k++) send_beat(1'b0, 8'h5a, 8'h00);
      send_beat(1'b0, 8'd0, 8'h00, 1'b1, ST_TOO_LONG);
      send_string(MAX_LEN, -1, 1'b0);

      // Reduced table: with only slot 1 usable, fresh strings soon find it full.
      write_slot_count(9'd2);
      send_beat(1'b1, 8'h00, 8'd2, 1'b1, ST_BAD_INTERN);
      send_string(3, -1, 1'b0);
      send_string(4, -1, 1'b0);
      send_string(5, -1, 1'b0);

      // Random part, over several slot counts; the receiver holds off once and the
      // block is run back to back for a while.
      foreach (settings[i]) begin
         write_slot_count(settings[i]);
         if (i == 3) hold_requests++;
         calm = (i == 5);
         random_phase(44);
      end
      calm = 1'b0;

      wait_drained();
      $display("Sent %0d beats over several slot counts; %0d results, %0d insertions, %0d errors.",
               items_sent, results_seen, inserts_seen, errors_seen);
      $display("Store ended with %0d of %0d bytes in use.", shadow_used, STORE_BYTES);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ string_intern_table.f @@
rtl/core/sit_pkg.sv
rtl/core/sit_ram.sv
rtl/core/sit_mod.sv
rtl/core/string_intern_table.sv
tb/string_intern_table_tb.sv
